// ----- rtl/h4dt_pkg.sv -----
// Shared constants, types and a helper function of the 4D direction tracker.
package h4dt_pkg;

  // Angle and output fixed-point formats
  localparam int unsigned ANGLE_FRAC_BITS = 6;
  localparam int unsigned OUT_FRAC_BITS   = 14;

  localparam int unsigned ANG_QUARTER = 90 << ANGLE_FRAC_BITS;
  localparam int unsigned ANG_HALF    = 180 << ANGLE_FRAC_BITS;
  localparam int unsigned ANG_FULL    = 360 << ANGLE_FRAC_BITS;

  // Field widths
  localparam int unsigned VAL_W  = 16;
  localparam int unsigned POL_W  = 14;
  localparam int unsigned PHI_W  = 15;
  localparam int unsigned COMP_W = 16;
  localparam int unsigned REM_W  = $clog2(ANG_QUARTER);

  // Q30 arithmetic
  localparam logic [31:0] PI_Q30   = 32'd3373259426;
  localparam logic [31:0] ONE_Q30  = 32'd1073741824;
  localparam int unsigned MAG_W    = 31;
  localparam int unsigned SERIES_TERMS = 10;

  // Final rounding shifts
  localparam int unsigned SH2 = 60 - OUT_FRAC_BITS;
  localparam int unsigned SH1 = 30 - OUT_FRAC_BITS;
  localparam logic [63:0] RND30 = 64'd1 << 29;
  localparam logic [63:0] RND2  = (SH2 == 0) ? 64'd0 : (64'd1 << (SH2 - 1));
  localparam logic [63:0] RND1  = (SH1 == 0) ? 64'd0 : (64'd1 << (SH1 - 1));

  // Shared multiplier and serial divider
  localparam int unsigned MUL_W      = 32;
  localparam int unsigned DIV_W      = 45;
  localparam int unsigned DIVR_W     = 14;
  localparam int unsigned DIV_BITS   = 3;
  localparam int unsigned DIV_ITERS  = DIV_W / DIV_BITS;
  localparam int unsigned DIV_CNT_W  = $clog2(DIV_ITERS);

  typedef struct packed {
    logic [PHI_W-1:0] phi;
    logic [POL_W-1:0] az;
    logic [POL_W-1:0] pol;
  } h4dt_angles_t;

  typedef struct packed {
    logic             neg;
    logic [MAG_W-1:0] mag;
  } h4dt_trig_t;

  typedef struct packed {
    logic              start;
    logic [DIV_W-1:0]  dividend;
    logic [DIVR_W-1:0] divisor;
  } h4dt_div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quot;
  } h4dt_div_rsp_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_XMUL,
    ST_XDIV,
    ST_XWAIT,
    ST_X2MUL,
    ST_X2GET,
    ST_TMUL,
    ST_TDIV,
    ST_TWAIT,
    ST_PSA,
    ST_PT,
    ST_PX,
    ST_PY,
    ST_PZ,
    ST_OUT
  } h4dt_state_e;

  // Series divisor n*(n+1) for term k; n starts at 2 for sine, 1 for cosine
  function automatic logic [8:0] series_div(logic odd, logic [3:0] k);
    logic [4:0] n;
    logic [4:0] n1;
    n  = {k, 1'b0} + (odd ? 5'd2 : 5'd1);
    n1 = n + 5'd1;
    return 9'(n) * 9'(n1);
  endfunction

endpackage

// ----- rtl/hyperspherical_4d_direction_tracker_unit.sv -----
// Top level: 4D direction tracker, angles to Cartesian unit vector.
//
//  channel  dir  transfer when          payload
//  s_axis   in   tvalid & tready        tuser: command; tdata: polar, azimuth, phi values
//  m_axis   out  tvalid & tready        tdata: x, y, z, w, polar, azimuth, phi now
//
// Most of an item's work is done on the shared serial divider: 63 divisions per
// item (one radian scaling and twenty series terms for each of three angles),
// at 3 quotient bits a cycle, each after a product on the shared 32x32 multiplier.
// Reset leaves polar at 0 and azimuth and phi at 90 degrees; no clearing pass.
// Input is taken only while the sequencer is idle. A finished result sits in the
// output register, so a new item may be taken while it waits; a second result
// then stalls the sequencer until the first one has been transferred.
module hyperspherical_4d_direction_tracker_unit (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // [15:0] polar_value, [31:16] azimuth_value, [47:32] phi_value
  input  logic [47:0]  s_axis_tdata,
  // [0] command
  input  logic [0:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [15:0] comp_x, [31:16] comp_y, [47:32] comp_z, [63:48] comp_w,
  // [77:64] polar_now, [91:78] azimuth_now, [106:92] phi_now, [111:107] zero
  output logic [111:0] m_axis_tdata
);
  import h4dt_pkg::*;

  localparam logic [3:0] K_LAST = 4'(SERIES_TERMS - 1);

  // signed component from an unsigned product, rounded half up in magnitude
  function automatic logic [COMP_W-1:0] to_comp(logic [63:0] p, logic neg);
    logic [63:0]       m;
    logic [COMP_W-1:0] v;
    m = (p + RND2) >> SH2;
    v = m[COMP_W-1:0];
    return neg ? (COMP_W'(0) - v) : v;
  endfunction

  h4dt_state_e state_q, state_d;

  h4dt_angles_t ang_q, ang_d, ang_new;
  logic [1:0]   idx_q, idx_d;          // 0 polar, 1 azimuth, 2 phi
  logic [3:0]   k_q, k_d;              // series term
  logic         odd_q, odd_d;          // sine series when set
  logic [31:0]  x_q, x_d;              // remainder in radians, Q30
  logic [31:0]  x2_q, x2_d;
  logic [31:0]  term_q, term_d;
  logic signed [34:0] sum_q, sum_d;
  logic [MAG_W-1:0]   sv_q, sv_d;      // sine series result of this angle
  logic [31:0]  t_q, t_d;              // sin(phi) * sin(azimuth)
  logic [COMP_W-1:0]  cx_q, cx_d, cy_q, cy_d;
  h4dt_trig_t   sin_q [3];
  h4dt_trig_t   sin_d [3];
  h4dt_trig_t   cos_q [3];
  h4dt_trig_t   cos_d [3];

  logic                          out_valid_q, out_valid_d;
  logic [3:0][COMP_W-1:0]        out_comp_q, out_comp_d;
  h4dt_angles_t                  out_ang_q, out_ang_d;

  logic [MUL_W-1:0]   mul_a, mul_b;
  logic [2*MUL_W-1:0] prod;
  h4dt_div_req_t      div_req;
  h4dt_div_rsp_t      div_rsp;

  logic [PHI_W-1:0]   ang_cur;
  logic [1:0]         quad_cur;
  logic [REM_W-1:0]   rem_cur;
  logic signed [34:0] sum_acc;
  logic [MAG_W-1:0]   sum_clamp;
  logic [63:0]        w_round;

  h4dt_angle_upd u_angle_upd (
    .cmd_i     (s_axis_tuser[0]),
    .pol_val_i ($signed(s_axis_tdata[15:0])),
    .az_val_i  ($signed(s_axis_tdata[31:16])),
    .phi_val_i ($signed(s_axis_tdata[47:32])),
    .cur_i     (ang_q),
    .nxt_o     (ang_new)
  );

  h4dt_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  h4dt_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // angle under work, split into quadrant and remainder
  always_comb begin
    unique case (idx_q)
      2'd0:    ang_cur = PHI_W'(ang_q.pol);
      2'd1:    ang_cur = PHI_W'(ang_q.az);
      default: ang_cur = ang_q.phi;
    endcase
    priority if (ang_cur >= PHI_W'(3 * ANG_QUARTER)) begin
      quad_cur = 2'd3;
      rem_cur  = REM_W'(ang_cur - PHI_W'(3 * ANG_QUARTER));
    end else if (ang_cur >= PHI_W'(2 * ANG_QUARTER)) begin
      quad_cur = 2'd2;
      rem_cur  = REM_W'(ang_cur - PHI_W'(2 * ANG_QUARTER));
    end else if (ang_cur >= PHI_W'(ANG_QUARTER)) begin
      quad_cur = 2'd1;
      rem_cur  = REM_W'(ang_cur - PHI_W'(ANG_QUARTER));
    end else begin
      quad_cur = 2'd0;
      rem_cur  = REM_W'(ang_cur);
    end
  end

  // series accumulation: terms alternate, first correction subtracts
  always_comb begin
    if (k_q[0]) begin
      sum_acc = sum_q + $signed({3'b0, div_rsp.quot[31:0]});
    end else begin
      sum_acc = sum_q - $signed({3'b0, div_rsp.quot[31:0]});
    end
    if (sum_acc < 0) begin
      sum_clamp = '0;
    end else if (sum_acc > $signed({3'b0, ONE_Q30})) begin
      sum_clamp = MAG_W'(ONE_Q30);
    end else begin
      sum_clamp = sum_acc[MAG_W-1:0];
    end
  end

  assign w_round = (64'(cos_q[2].mag) + RND1) >> SH1;

  always_comb begin
    state_d     = state_q;
    ang_d       = ang_q;
    idx_d       = idx_q;
    k_d         = k_q;
    odd_d       = odd_q;
    x_d         = x_q;
    x2_d        = x2_q;
    term_d      = term_q;
    sum_d       = sum_q;
    sv_d        = sv_q;
    t_d         = t_q;
    cx_d        = cx_q;
    cy_d        = cy_q;
    sin_d       = sin_q;
    cos_d       = cos_q;
    out_valid_d = out_valid_q;
    out_comp_d  = out_comp_q;
    out_ang_d   = out_ang_q;
    mul_a       = '0;
    mul_b       = '0;
    div_req     = '0;

    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          ang_d   = ang_new;
          idx_d   = 2'd0;
          state_d = ST_XMUL;
        end
      end
      // x = round(r * pi / 180 deg) in Q30
      ST_XMUL: begin
        mul_a   = MUL_W'(rem_cur);
        mul_b   = PI_Q30;
        state_d = ST_XDIV;
      end
      ST_XDIV: begin
        div_req.start    = 1'b1;
        div_req.dividend = prod[DIV_W-1:0] + DIV_W'(ANG_HALF / 2);
        div_req.divisor  = DIVR_W'(ANG_HALF);
        state_d          = ST_XWAIT;
      end
      ST_XWAIT: begin
        if (div_rsp.done) begin
          x_d     = div_rsp.quot[31:0];
          state_d = ST_X2MUL;
        end
      end
      ST_X2MUL: begin
        mul_a   = x_q;
        mul_b   = x_q;
        state_d = ST_X2GET;
      end
      ST_X2GET: begin
        x2_d    = prod[61:30];
        term_d  = x_q;
        sum_d   = $signed({3'b0, x_q});
        odd_d   = 1'b1;
        k_d     = '0;
        state_d = ST_TMUL;
      end
      ST_TMUL: begin
        mul_a   = term_q;
        mul_b   = x2_q;
        state_d = ST_TDIV;
      end
      ST_TDIV: begin
        div_req.start    = 1'b1;
        div_req.dividend = DIV_W'(prod[62:30]);
        div_req.divisor  = DIVR_W'(series_div(odd_q, k_q));
        state_d          = ST_TWAIT;
      end
      ST_TWAIT: begin
        if (div_rsp.done) begin
          term_d = div_rsp.quot[31:0];
          sum_d  = sum_acc;
          if (k_q == K_LAST) begin
            if (odd_q) begin
              // sine done, restart for cosine
              sv_d    = sum_clamp;
              odd_d   = 1'b0;
              term_d  = ONE_Q30;
              sum_d   = $signed({3'b0, ONE_Q30});
              k_d     = '0;
              state_d = ST_TMUL;
            end else begin
              // quadrant symmetry
              unique case (quad_cur)
                2'd0: begin
                  sin_d[idx_q] = '{neg: 1'b0, mag: sv_q};
                  cos_d[idx_q] = '{neg: 1'b0, mag: sum_clamp};
                end
                2'd1: begin
                  sin_d[idx_q] = '{neg: 1'b0, mag: sum_clamp};
                  cos_d[idx_q] = '{neg: 1'b1, mag: sv_q};
                end
                2'd2: begin
                  sin_d[idx_q] = '{neg: 1'b1, mag: sv_q};
                  cos_d[idx_q] = '{neg: 1'b1, mag: sum_clamp};
                end
                default: begin
                  sin_d[idx_q] = '{neg: 1'b1, mag: sum_clamp};
                  cos_d[idx_q] = '{neg: 1'b0, mag: sv_q};
                end
              endcase
              if (idx_q == 2'd2) begin
                state_d = ST_PSA;
              end else begin
                idx_d   = idx_q + 2'd1;
                state_d = ST_XMUL;
              end
            end
          end else begin
            k_d     = k_q + 4'd1;
            state_d = ST_TMUL;
          end
        end
      end
      // products; sin_q/cos_q index 0 polar, 1 azimuth, 2 phi
      ST_PSA: begin
        mul_a   = MUL_W'(sin_q[2].mag);
        mul_b   = MUL_W'(sin_q[1].mag);
        state_d = ST_PT;
      end
      ST_PT: begin
        t_d     = 32'((prod + RND30) >> 30);
        state_d = ST_PX;
      end
      ST_PX: begin
        mul_a   = t_q;
        mul_b   = MUL_W'(sin_q[0].mag);
        state_d = ST_PY;
      end
      ST_PY: begin
        cx_d    = to_comp(prod, sin_q[2].neg ^ sin_q[1].neg ^ sin_q[0].neg);
        mul_a   = t_q;
        mul_b   = MUL_W'(cos_q[0].mag);
        state_d = ST_PZ;
      end
      ST_PZ: begin
        cy_d    = to_comp(prod, sin_q[2].neg ^ sin_q[1].neg ^ cos_q[0].neg);
        mul_a   = MUL_W'(sin_q[2].mag);
        mul_b   = MUL_W'(cos_q[1].mag);
        state_d = ST_OUT;
      end
      // operands held so the z product stays put while the output waits
      ST_OUT: begin
        mul_a = MUL_W'(sin_q[2].mag);
        mul_b = MUL_W'(cos_q[1].mag);
        if (!out_valid_q || m_axis_tready) begin
          out_comp_d[0] = cx_q;
          out_comp_d[1] = cy_q;
          out_comp_d[2] = to_comp(prod, sin_q[2].neg ^ cos_q[1].neg);
          out_comp_d[3] = cos_q[2].neg ? (COMP_W'(0) - w_round[COMP_W-1:0])
                                       : w_round[COMP_W-1:0];
          out_ang_d     = ang_q;
          out_valid_d   = 1'b1;
          state_d       = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      ang_q.pol   <= '0;
      ang_q.az    <= POL_W'(ANG_QUARTER);
      ang_q.phi   <= PHI_W'(ANG_QUARTER);
      idx_q       <= '0;
      k_q         <= '0;
      odd_q       <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      ang_q       <= ang_d;
      idx_q       <= idx_d;
      k_q         <= k_d;
      odd_q       <= odd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q        <= x_d;
    x2_q       <= x2_d;
    term_q     <= term_d;
    sum_q      <= sum_d;
    sv_q       <= sv_d;
    t_q        <= t_d;
    cx_q       <= cx_d;
    cy_q       <= cy_d;
    sin_q      <= sin_d;
    cos_q      <= cos_d;
    out_comp_q <= out_comp_d;
    out_ang_q  <= out_ang_d;
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'b0, out_ang_q.phi, out_ang_q.az, out_ang_q.pol,
                          out_comp_q[3], out_comp_q[2], out_comp_q[1], out_comp_q[0]};

endmodule

// ----- rtl/h4dt_mul.sv -----
// Shared unsigned 32x32 multiplier with registered product.
module h4dt_mul (
  input  logic                           clk_i,
  input  logic [h4dt_pkg::MUL_W-1:0]     a_i,
  input  logic [h4dt_pkg::MUL_W-1:0]     b_i,
  output logic [2*h4dt_pkg::MUL_W-1:0]   p_o
);
  import h4dt_pkg::*;

  logic [2*MUL_W-1:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= (2*MUL_W)'(a_i) * (2*MUL_W)'(b_i);
  end

  assign p_o = p_q;

endmodule

// ----- rtl/h4dt_div.sv -----
// Serial restoring divider, DIV_BITS quotient bits per cycle while it runs.
module h4dt_div (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  h4dt_pkg::h4dt_div_req_t req_i,
  output h4dt_pkg::h4dt_div_rsp_t rsp_o
);
  import h4dt_pkg::*;

  logic [DIV_W-1:0]     work_q, work_d;
  logic [DIVR_W-1:0]    rem_q, rem_d;
  logic [DIVR_W-1:0]    dvs_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic                 run_q;
  logic                 done_q;
  logic                 last;

  assign last = (cnt_q == DIV_CNT_W'(DIV_ITERS - 1));

  // shift in DIV_BITS dividend bits one at a time, subtract divisor when it fits
  always_comb begin
    logic [DIVR_W:0] sh;
    work_d = work_q;
    rem_d  = rem_q;
    for (int j = 0; j < DIV_BITS; j++) begin
      sh     = {rem_d, work_d[DIV_W-1]};
      work_d = {work_d[DIV_W-2:0], 1'b0};
      if (sh >= {1'b0, dvs_q}) begin
        sh        = sh - {1'b0, dvs_q};
        work_d[0] = 1'b1;
      end
      rem_d = sh[DIVR_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= run_q && last;
      if (req_i.start) begin
        run_q <= 1'b1;
        cnt_q <= '0;
      end else if (run_q) begin
        cnt_q <= cnt_q + DIV_CNT_W'(1);
        if (last) begin
          run_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      work_q <= req_i.dividend;
      rem_q  <= '0;
      dvs_q  <= req_i.divisor;
    end else if (run_q) begin
      work_q <= work_d;
      rem_q  <= rem_d;
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = work_q;

endmodule

// ----- rtl/h4dt_angle_upd.sv -----
// Angle update: set or add deltas, clamp polar/azimuth, wrap phi.
module h4dt_angle_upd (
  input  logic                                cmd_i,
  input  logic signed [h4dt_pkg::VAL_W-1:0]   pol_val_i,
  input  logic signed [h4dt_pkg::VAL_W-1:0]   az_val_i,
  input  logic signed [h4dt_pkg::VAL_W-1:0]   phi_val_i,
  input  h4dt_pkg::h4dt_angles_t              cur_i,
  output h4dt_pkg::h4dt_angles_t              nxt_o
);
  import h4dt_pkg::*;

  localparam logic signed [17:0] HALF_S  = 18'(ANG_HALF);
  localparam logic signed [17:0] FULL_S  = 18'(ANG_FULL);
  localparam logic signed [17:0] FULL2_S = 18'(2 * ANG_FULL);

  function automatic logic [POL_W-1:0] clamp_half(logic signed [17:0] v);
    logic [POL_W-1:0] r;
    if (v < 0) begin
      r = '0;
    end else if (v > HALF_S) begin
      r = POL_W'(ANG_HALF);
    end else begin
      r = v[POL_W-1:0];
    end
    return r;
  endfunction

  logic signed [17:0] pol_v, az_v, phi_v, phi_t;

  always_comb begin
    if (cmd_i) begin
      pol_v = 18'(pol_val_i);
      az_v  = 18'(az_val_i);
      phi_v = 18'(phi_val_i);
    end else begin
      pol_v = $signed({4'b0, cur_i.pol}) + 18'(pol_val_i);
      az_v  = $signed({4'b0, cur_i.az}) + 18'(az_val_i);
      phi_v = $signed({3'b0, cur_i.phi}) + 18'(phi_val_i);
    end

    // at most two turns off in either direction
    phi_t = phi_v;
    if (phi_v < 0) begin
      phi_t = phi_v + FULL_S;
      if (phi_t < 0) begin
        phi_t = phi_t + FULL_S;
      end
    end else if (phi_v >= FULL2_S) begin
      phi_t = phi_v - FULL2_S;
    end else if (phi_v >= FULL_S) begin
      phi_t = phi_v - FULL_S;
    end

    nxt_o.pol = clamp_half(pol_v);
    nxt_o.az  = clamp_half(az_v);
    nxt_o.phi = phi_t[PHI_W-1:0];
  end

endmodule

// ----- bench/tb_hyperspherical_4d_direction_tracker_unit.sv -----
`timescale 1ns / 1ps
// Self-checking bench for the 4D direction tracker: stream stimulus, predicted vectors, stalls.
module tb_hyperspherical_4d_direction_tracker_unit;
  import h4dt_pkg::ANG_QUARTER;
  import h4dt_pkg::ANG_HALF;
  import h4dt_pkg::ANG_FULL;
  import h4dt_pkg::PI_Q30;
  import h4dt_pkg::ONE_Q30;
  import h4dt_pkg::SERIES_TERMS;
  import h4dt_pkg::SH1;
  import h4dt_pkg::SH2;
  import h4dt_pkg::POL_W;
  import h4dt_pkg::PHI_W;

  // Command codes carried on s_axis_tuser
  localparam logic CMD_ROTATE = 1'b0;
  localparam logic CMD_SET    = 1'b1;

  // Receiver stall patterns
  localparam int RX_OPEN    = 0;
  localparam int RX_CHOPPY  = 1;
  localparam int RX_STARVED = 2;

  localparam int QUARTER_S = ANG_QUARTER;
  localparam int HALF_S    = ANG_HALF;
  localparam int FULL_S    = ANG_FULL;
  localparam logic [63:0] PI_L  = PI_Q30;
  localparam logic [63:0] ONE_L = ONE_Q30;
  localparam longint ONE_S = ONE_Q30;

  localparam int RANDOM_ITEMS = 2000;
  localparam int TAIL_CYCLES  = 1500;   // idle wait after the last test, for stray results

  // Result word as it sits in m_axis_tdata[106:0], comp_x in the low bits
  typedef struct packed {
    logic [PHI_W-1:0] phi;
    logic [POL_W-1:0] az;
    logic [POL_W-1:0] pol;
    logic [15:0]      w;
    logic [15:0]      z;
    logic [15:0]      y;
    logic [15:0]      x;
  } dir_result_t;

  typedef struct packed {
    logic        neg;
    logic [63:0] mag;
  } signed_mag_t;

  logic         clk_i         = 1'b0;
  logic         rst_ni        = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [47:0]  s_axis_tdata  = '0;
  logic [0:0]   s_axis_tuser  = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [111:0] m_axis_tdata;

  // Predicted direction angles, 1/64 degree
  int track_pol = 0;
  int track_az  = QUARTER_S;
  int track_phi = QUARTER_S;

  dir_result_t expected_dirs[$];
  dir_result_t rx_seen;
  dir_result_t rx_want;
  int          mismatch_count = 0;
  int          burst_left = 0;
  int          stall_mode = RX_OPEN;
  int          mode_left  = 0;

  hyperspherical_4d_direction_tracker_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #1 clk_i = ~clk_i;

  // ---------------------------------------------------------------- predictor

  function automatic int clamp_half(int v);
    if (v < 0) return 0;
    if (v > HALF_S) return HALF_S;
    return v;
  endfunction

  function automatic int wrap_full(int v);
    int r;
    r = v % FULL_S;
    if (r < 0) r += FULL_S;
    return r;
  endfunction

  // Q30 Taylor series of sin (odd) or cos on [0, pi/2), clamped to [0, 1.0]
  function automatic logic [63:0] series_q30(logic [63:0] x, logic odd);
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] n;
    longint      acc;
    int          k;
    x2   = (x * x) >> 30;
    term = odd ? x : ONE_L;
    acc  = $signed(term);
    n    = odd ? 64'd2 : 64'd1;
    for (k = 0; k < SERIES_TERMS; k++) begin
      term = ((term * x2) >> 30) / (n * (n + 64'd1));
      n    = n + 64'd2;
      if (k % 2 == 1) acc += $signed(term);
      else acc -= $signed(term);
    end
    if (acc < 0) acc = 0;
    if (acc > ONE_S) acc = ONE_S;
    return acc;
  endfunction

  function automatic void angle_trig(input int a, output signed_mag_t s, output signed_mag_t c);
    int          quad;
    logic [63:0] r;
    logic [63:0] x;
    logic [63:0] sv;
    logic [63:0] cv;
    quad = (a / QUARTER_S) % 4;
    r    = a % QUARTER_S;
    x    = (r * PI_L + HALF_S / 2) / HALF_S;
    sv   = series_q30(x, 1'b1);
    cv   = series_q30(x, 1'b0);
    // quadrant symmetry: swap magnitudes on odd quadrants, signs by quadrant
    s.mag = (quad % 2 == 1) ? cv : sv;
    c.mag = (quad % 2 == 1) ? sv : cv;
    s.neg = (quad >= 2);
    c.neg = (quad == 1) || (quad == 2);
  endfunction

  function automatic logic [63:0] round_sh(logic [63:0] m, int sh);
    return (m + (64'd1 << (sh - 1))) >> sh;
  endfunction

  function automatic logic [15:0] apply_sign(logic [63:0] mag, logic neg);
    logic [63:0] v;
    v = neg ? (64'd0 - mag) : mag;
    return v[15:0];
  endfunction

  function automatic dir_result_t predict_direction(logic cmd, logic signed [15:0] pv,
                                                    logic signed [15:0] av,
                                                    logic signed [15:0] fv);
    signed_mag_t sp, cp, sa, ca, sf, cf;
    logic [63:0] t;
    dir_result_t r;
    if (cmd == CMD_SET) begin
      track_pol = clamp_half(pv);
      track_az  = clamp_half(av);
      track_phi = wrap_full(fv);
    end else begin
      track_pol = clamp_half(track_pol + pv);
      track_az  = clamp_half(track_az + av);
      track_phi = wrap_full(track_phi + fv);
    end
    angle_trig(track_pol, sp, cp);
    angle_trig(track_az, sa, ca);
    angle_trig(track_phi, sf, cf);
    t     = round_sh(sf.mag * sa.mag, 30);
    r.x   = apply_sign(round_sh(t * sp.mag, SH2), sf.neg ^ sa.neg ^ sp.neg);
    r.y   = apply_sign(round_sh(t * cp.mag, SH2), sf.neg ^ sa.neg ^ cp.neg);
    r.z   = apply_sign(round_sh(sf.mag * ca.mag, SH2), sf.neg ^ ca.neg);
    r.w   = apply_sign(round_sh(cf.mag, SH1), cf.neg);
    r.pol = track_pol[POL_W-1:0];
    r.az  = track_az[POL_W-1:0];
    r.phi = track_phi[PHI_W-1:0];
    return r;
  endfunction

  // ---------------------------------------------------------------- sender

  // One input transfer; bursts of random length, random gaps between bursts
  task automatic send_command(input logic cmd, input logic [15:0] pv, input logic [15:0] av,
                              input logic [15:0] fv);
    int gap;
    if (burst_left == 0) begin
      s_axis_tvalid <= 1'b0;
      gap = ($urandom_range(0, 15) == 0) ? $urandom_range(1, 1400) : $urandom_range(1, 12);
      repeat (gap) @(posedge clk_i);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {fv, av, pv};
    s_axis_tuser  <= cmd;
    do @(posedge clk_i); while (s_axis_tready !== 1'b1);
    expected_dirs.push_back(predict_direction(cmd, pv, av, fv));
    burst_left--;
  endtask

  // Hold off the sender until every predicted result has been transferred
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    do @(posedge clk_i); while (expected_dirs.size() != 0);
  endtask

  // ---------------------------------------------------------------- receiver / checker

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch, expected %0d actual %0d", $time, name,
               $signed(want), $signed(got));
      mismatch_count++;
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1) begin
      if (expected_dirs.size() == 0) begin
        $display("%0t ns: result with nothing expected, actual tdata %h", $time,
                 m_axis_tdata);
        mismatch_count++;
      end else begin
        rx_want = expected_dirs.pop_front();
        rx_seen = m_axis_tdata[106:0];
        check_field("comp_x", rx_want.x, rx_seen.x);
        check_field("comp_y", rx_want.y, rx_seen.y);
        check_field("comp_z", rx_want.z, rx_seen.z);
        check_field("comp_w", rx_want.w, rx_seen.w);
        check_field("polar_now", 16'(rx_want.pol), 16'(rx_seen.pol));
        check_field("azimuth_now", 16'(rx_want.az), 16'(rx_seen.az));
        check_field("phi_now", 16'(rx_want.phi), 16'(rx_seen.phi));
        check_field("pad", 16'd0, 16'(m_axis_tdata[111:107]));
      end
    end
    // stall pattern: stretches of always-ready, choppy and mostly-stalled
    if (mode_left == 0) begin
      stall_mode = $urandom_range(RX_OPEN, RX_STARVED);
      mode_left  = $urandom_range(16, 600);
    end else begin
      mode_left--;
    end
    case (stall_mode)
      RX_OPEN:   m_axis_tready <= 1'b1;
      RX_CHOPPY: m_axis_tready <= ($urandom_range(0, 3) != 0);
      default:   m_axis_tready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  // ---------------------------------------------------------------- tests

  // Zero rotation shows the reset direction
  task automatic test_reset_direction();
    send_command(CMD_ROTATE, 16'd0, 16'd0, 16'd0);
    wait_drained();
  endtask

  // Set values at and past the limits: saturation of polar/azimuth, phi wrap both ways
  task automatic test_set_limits();
    send_command(CMD_SET, 16'd0, 16'd0, 16'd0);
    send_command(CMD_SET, 16'd11520, 16'd11520, 16'd23039);
    send_command(CMD_SET, 16'd11521, 16'd23040, 16'd23040);
    send_command(CMD_SET, -16'sd1, -16'sd23040, -16'sd1);
    send_command(CMD_SET, 16'h7fff, 16'h8000, 16'h8000);
    send_command(CMD_SET, 16'h8000, 16'h7fff, 16'h7fff);
    send_command(CMD_SET, 16'hffff, 16'h5555, 16'haaaa);
    wait_drained();
  endtask

  // Deltas that saturate, wrap, and take full turns
  task automatic test_rotate_limits();
    send_command(CMD_SET, 16'd11500, 16'd20, 16'd23000);
    send_command(CMD_ROTATE, 16'd100, -16'sd100, 16'd100);
    send_command(CMD_ROTATE, 16'h8000, 16'h7fff, 16'h8000);
    send_command(CMD_ROTATE, 16'h7fff, 16'h8000, 16'h7fff);
    send_command(CMD_ROTATE, 16'd1, 16'd1, -16'sd1);
    send_command(CMD_ROTATE, -16'sd1, -16'sd1, 16'd23040);
    send_command(CMD_ROTATE, 16'd0, 16'd0, -16'sd23040);
    wait_drained();
  endtask

  // Exact right angles, checked against the predicted exact 0 and +-1.0 components
  task automatic test_right_angles();
    send_command(CMD_SET, 16'd5760, 16'd5760, 16'd5760);
    send_command(CMD_SET, 16'd11520, 16'd0, 16'd11520);
    send_command(CMD_SET, 16'd0, 16'd11520, 16'd17280);
    send_command(CMD_SET, 16'd5760, 16'd11520, 16'd0);
    send_command(CMD_ROTATE, -16'sd5760, -16'sd5760, 16'd5760);
    wait_drained();
  endtask

  function automatic logic [15:0] small_delta();
    if ($urandom_range(0, 3) == 0) return $urandom_range(0, 2) - 1;
    return $urandom_range(0, 1200) - 600;
  endfunction

  // Mostly small rotations around the current direction, plus sets and raw noise
  task automatic test_random_walk();
    int          i;
    int          pick;
    logic        cmd;
    logic [15:0] pv, av, fv;
    for (i = 0; i < RANDOM_ITEMS; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        cmd = CMD_ROTATE;
        pv  = small_delta();
        av  = small_delta();
        fv  = small_delta();
      end else if (pick < 70) begin
        cmd = CMD_ROTATE;
        pv  = $urandom();
        av  = $urandom();
        fv  = $urandom();
      end else if (pick < 85) begin
        cmd = CMD_SET;
        pv  = $urandom_range(0, HALF_S);
        av  = $urandom_range(0, HALF_S);
        fv  = $urandom_range(0, FULL_S - 1);
      end else if (pick < 92) begin
        // quadrant boundaries, some past the limits or negative
        cmd = CMD_SET;
        pv  = $urandom_range(0, 4) * QUARTER_S;
        av  = $urandom_range(0, 4) * QUARTER_S;
        fv  = ($urandom_range(0, 5) - 1) * QUARTER_S;
      end else begin
        cmd = $urandom_range(0, 1);
        pv  = $urandom();
        av  = $urandom();
        fv  = $urandom();
      end
      send_command(cmd, pv, av, fv);
      if (i % 400 == 399) wait_drained();
    end
    wait_drained();
  endtask

  // ---------------------------------------------------------------- sequence

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_direction();
    test_set_limits();
    test_rotate_limits();
    test_right_angles();
    test_random_walk();
    // catch any stray result after the last expected one
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("[hyperspherical_4d_direction_tracker_unit] OK");
    end else begin
      $display("[hyperspherical_4d_direction_tracker_unit] ERROR");
    end
    $finish;
  end

  // Run limit, several times the slowest correct run
  initial begin
    #30_000_000;
    $display("[hyperspherical_4d_direction_tracker_unit] ERROR");
    $finish;
  end

endmodule
